>>> rtl/core/dcrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrs_pkg
// Shared types and fixed field widths for the divisor count range sum block.
// ----------------------------------------------------------------------------
package dcrs_pkg;

  // fixed widths of the query and result fields
  localparam int unsigned BOUND_W     = 17;
  localparam int unsigned SUM_FIELD_W = 20;
  localparam logic [SUM_FIELD_W-1:0] SUM_FIELD_MAX = '1;

  // controller to datapath commands, at most one set per cycle
  typedef struct packed {
    logic clear_step;   // write zero at the sweep pointer
    logic sieve_step;   // add to the entry at the sieve product
    logic prefix_step;  // accumulate the entry at the sweep pointer
    logic query;        // a query transfer is taken this cycle
  } dcrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ptr_last;     // sweep pointer sits on the last table entry
    logic sieve_last;   // current sieve product is the final one
  } dcrs_status_t;

endpackage

>>> rtl/core/dcrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrs_ctrl
// Build sequencer: clear, sieve, prefix, a flush state, then ready for queries.
// ----------------------------------------------------------------------------
module dcrs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  dcrs_pkg::dcrs_status_t status,
  output dcrs_pkg::dcrs_cmd_t    cmd,
  output logic                   busy
);
  import dcrs_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_SIEVE  = 5'b00010,
    S_PREFIX = 5'b00100,
    S_FLUSH  = 5'b01000,
    S_READY  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.ptr_last) begin
          state_next = S_SIEVE;
        end
      end
      S_SIEVE: begin
        cmd.sieve_step = 1'b1;
        if (status.sieve_last) begin
          state_next = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.prefix_step = 1'b1;
        if (status.ptr_last) begin
          state_next = S_FLUSH;
        end
      end
      // last prefix write lands here, before any query read
      S_FLUSH: begin
        state_next = S_READY;
      end
      S_READY: begin
        cmd.query = start;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_READY);

endmodule

>>> rtl/core/dcrs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrs_dp
// Table memory, sieve and sweep counters, and the two-read query pipeline.
// ----------------------------------------------------------------------------
module dcrs_dp #(
  parameter int unsigned MAX_N     = 65536,
  parameter int unsigned SUM_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dcrs_pkg::dcrs_cmd_t                 cmd,
  output dcrs_pkg::dcrs_status_t              status,
  input  logic [dcrs_pkg::BOUND_W-1:0]        low_bound,
  input  logic [dcrs_pkg::BOUND_W-1:0]        high_bound,
  output logic                                done,
  output logic [dcrs_pkg::SUM_FIELD_W-1:0]    divisor_sum,
  output logic                                range_error
);
  import dcrs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_N + 1);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned OW = AW / 2 + 2;
  // prefix total is below MAX_N * (1 + AW)
  localparam int unsigned TW = AW + $clog2(AW + 2);
  localparam int unsigned CW = (AW > BOUND_W) ? AW : BOUND_W;
  localparam int unsigned SW = (TW > SUM_FIELD_W) ? TW : SUM_FIELD_W;

  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_N);
  localparam logic [IW-1:0] MAX_I    = IW'(MAX_N);
  localparam logic [CW-1:0] MAX_C    = CW'(MAX_N);
  localparam logic [SUM_FIELD_W-1:0] SAT = (SUM_WIDTH >= SUM_FIELD_W) ? SUM_FIELD_MAX :
                                           SUM_FIELD_W'((1 << SUM_WIDTH) - 1);
  localparam logic [SW-1:0] SAT_W = SW'(SAT);

  logic [TW-1:0] mem [0:MAX_N];

  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [AW-1:0] waddr;
  logic          we;
  logic [TW-1:0] wdata;
  logic [TW-1:0] qa;
  logic [TW-1:0] qb;
  logic [TW-1:0] rd_a;

  logic [AW-1:0] ptr;
  logic [IW-1:0] idx;
  logic [IW-1:0] sq;
  logic [IW-1:0] nxt;
  logic [IW-1:0] sq_step;
  logic [OW-1:0] outer;
  logic          first;

  logic          pend;
  logic          pend_prefix;
  logic          pend_one;
  logic [AW-1:0] pend_addr;
  logic [TW-1:0] acc;
  logic          fwd_hit;
  logic [TW-1:0] fwd_data;

  logic [CW-1:0] lo_c;
  logic [CW-1:0] hi_c;
  logic [CW-1:0] hi_sat;
  logic [CW-1:0] below;
  logic          q_err;
  logic          q_use;
  logic          q1_valid;
  logic          q1_err;
  logic          q1_use;
  logic [TW-1:0] diff;
  logic [SW-1:0] diff_w;
  logic [SUM_FIELD_W-1:0] sum_sat;

  // sieve walks products outer*j by repeated add; next row starts at outer^2
  assign nxt     = idx + IW'(outer);
  assign sq_step = sq + IW'({outer, 1'b1});

  assign status.ptr_last   = (ptr == PTR_LAST);
  assign status.sieve_last = (nxt > MAX_I) && (sq_step > MAX_I);

  // query address generation
  assign lo_c   = CW'(low_bound);
  assign hi_c   = CW'(high_bound);
  assign hi_sat = (hi_c > MAX_C) ? MAX_C : hi_c;
  assign below  = (lo_c == '0) ? '0 : lo_c - 1'b1;
  assign q_err  = (low_bound > high_bound);
  assign q_use  = !q_err && (lo_c <= hi_sat);

  always_comb begin
    if (cmd.sieve_step) begin
      raddr_a = idx[AW-1:0];
    end else if (cmd.prefix_step) begin
      raddr_a = ptr;
    end else begin
      raddr_a = hi_sat[AW-1:0];
    end
  end

  assign raddr_b = below[AW-1:0];

  // same-cycle read of the entry being written returns stale data
  assign rd_a = fwd_hit ? fwd_data : qa;

  always_comb begin
    if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      if (pend_prefix) begin
        wdata = acc + rd_a;
      end else begin
        wdata = rd_a + (pend_one ? TW'(1) : TW'(2));
      end
    end else begin
      we    = cmd.clear_step;
      waddr = ptr;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      idx      <= IW'(1);
      sq       <= IW'(1);
      outer    <= OW'(1);
      first    <= 1'b1;
      pend     <= 1'b0;
      acc      <= '0;
      fwd_hit  <= 1'b0;
      q1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cmd.clear_step || cmd.prefix_step) begin
        if (ptr == PTR_LAST) begin
          ptr <= AW'(1);
        end else begin
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.sieve_step) begin
        if (nxt > MAX_I) begin
          outer <= outer + 1'b1;
          sq    <= sq_step;
          idx   <= sq_step;
          first <= 1'b1;
        end else begin
          idx   <= nxt;
          first <= 1'b0;
        end
      end
      pend <= cmd.sieve_step || cmd.prefix_step;
      if (pend && pend_prefix) begin
        acc <= wdata;
      end
      fwd_hit  <= we && (waddr == raddr_a);
      q1_valid <= cmd.query;
      done     <= q1_valid;
    end
  end

  assign diff    = rd_a - qb;
  assign diff_w  = SW'(diff);
  assign sum_sat = (diff_w > SAT_W) ? SAT : diff_w[SUM_FIELD_W-1:0];

  // payload
  always_ff @(posedge clk) begin
    pend_addr   <= raddr_a;
    pend_prefix <= cmd.prefix_step;
    pend_one    <= first;
    fwd_data    <= wdata;
    q1_err      <= q_err;
    q1_use      <= q_use;
    range_error <= q1_err;
    divisor_sum <= q1_use ? sum_sat : '0;
  end

endmodule

>>> rtl/core/divisor_count_range_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_count_range_sum
// Range sums of the divisor count d(n) over 0..MAX_N from a prefix-sum table.
// ----------------------------------------------------------------------------
// Usage:
//   After rst the block builds its table and holds busy high meanwhile: it
//   clears all MAX_N+1 entries, takes one sieve step per pair (i <= j,
//   i*j <= MAX_N; about 368k for MAX_N = 65536), forms the prefix sums and
//   passes a flush state. The table is a single memory with one write and
//   two read ports. A query transfer happens at a clock edge with start high
//   and busy low, carrying low_bound and high_bound. Once ready, busy stays
//   low and a query may be sent every cycle: the two table reads and the
//   subtraction are a two-stage pipeline. The result is registered out of
//   the second stage with done high for one cycle. The receiver cannot stall;
//   there is no backpressure and nothing is buffered beyond the pipeline.
//   low_bound above high_bound gives range_error with a zero sum. high_bound
//   is clamped to MAX_N, and the sum saturates at 2^SUM_WIDTH-1 (20-bit cap).
// ----------------------------------------------------------------------------
module divisor_count_range_sum #(
  parameter int unsigned MAX_N     = 65536,
  parameter int unsigned SUM_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [dcrs_pkg::BOUND_W-1:0]     low_bound,
  input  logic [dcrs_pkg::BOUND_W-1:0]     high_bound,
  output logic                             done,
  output logic [dcrs_pkg::SUM_FIELD_W-1:0] divisor_sum,
  output logic                             range_error
);
  import dcrs_pkg::*;

  dcrs_cmd_t    cmd;
  dcrs_status_t status;

  dcrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dcrs_dp #(
    .MAX_N     (MAX_N),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .low_bound   (low_bound),
    .high_bound  (high_bound),
    .done        (done),
    .divisor_sum (divisor_sum),
    .range_error (range_error)
  );

  // every result traces back to an earlier query transfer
  a_done_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.query, 2))
    else $error("result without a matching query transfer");

  // an error result never carries a sum
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (divisor_sum == '0))
    else $error("range error with nonzero sum");

  // build steps and queries never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.sieve_step, cmd.prefix_step, cmd.query}))
    else $error("overlapping datapath commands");

  // ready only after the prefix sweep has finished
  a_ready_after_build: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(cmd.prefix_step, 2))
    else $error("ready asserted before table build completed");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for divisor_count_range_sum. Waits out the table build
// after reset, then sends directed and random range queries, mostly with random
// idle gaps, and compares every result against a locally built prefix-sum table.
// ----------------------------------------------------------------------------
module tb_top;
  import dcrs_pkg::*;

  localparam int unsigned MAX_N          = 65536;
  localparam int unsigned SUM_WIDTH      = 20;
  localparam int unsigned BOUND_TOP      = (1 << BOUND_W) - 1;
  localparam int unsigned RANDOM_QUERIES = 1950;
  // the limit covers the whole build, during which nothing moves
  localparam int unsigned STALL_LIMIT    = 2_000_000;
  localparam int unsigned DIRECTED_COUNT = 20;

  typedef logic [BOUND_W-1:0]     bound_t;
  typedef logic [SUM_FIELD_W-1:0] sum_t;

  typedef struct packed {
    sum_t divisor_sum;
    logic range_error;
  } range_result_t;

  // bounds at the edges of the table, of the field, and swapped ends
  localparam bound_t EDGE_LO [DIRECTED_COUNT] = '{
    0, 0, 1, 65536, 0, 131071, 70000, 5, 131071, 65537,
    2, 1, 65535, 100, 0, 12, 65536, 65536, 1, 131070
  };
  localparam bound_t EDGE_HI [DIRECTED_COUNT] = '{
    0, 65536, 1, 65536, 131071, 131071, 100000, 4, 0, 65536,
    2, 65536, 65536, 50, 1, 12, 131071, 0, 0, 131071
  };

  class divisor_sum_tracker;
    int unsigned   prefix_counts[];
    range_result_t pending_sums[$];
    int unsigned   mismatches;

    function new();
      int unsigned i, j, n;
      prefix_counts = new[MAX_N + 1];
      mismatches = 0;
      // each pair i <= j with i*j in range contributes both divisors
      for (i = 1; i * i <= MAX_N; i++) begin
        for (j = i; i * j <= MAX_N; j++) begin
          prefix_counts[i * j] += (i == j) ? 1 : 2;
        end
      end
      for (n = 1; n <= MAX_N; n++) begin
        prefix_counts[n] += prefix_counts[n - 1];
      end
    endfunction

    function void add_query(bound_t lo, bound_t hi);
      range_result_t    r;
      longint unsigned  top, below, total, cap;
      r = '0;
      cap = (64'd1 << SUM_WIDTH) - 1;
      if (cap > SUM_FIELD_MAX) begin
        cap = SUM_FIELD_MAX;
      end
      if (lo > hi) begin
        r.range_error = 1'b1;
      end else begin
        top = (hi > MAX_N) ? MAX_N : hi;
        // low end past the table after clamping gives an empty range
        if (lo <= top) begin
          below = (lo == 0) ? 0 : lo - 1;
          total = prefix_counts[top] - prefix_counts[below];
          if (total > cap) begin
            total = cap;
          end
          r.divisor_sum = total[SUM_FIELD_W-1:0];
        end
      end
      pending_sums.push_back(r);
    endfunction

    function void check_sum(sum_t got_sum, logic got_error);
      range_result_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        $error("result with no query pending: divisor_sum %0d range_error %b",
               got_sum, got_error);
        return;
      end
      want = pending_sums.pop_front();
      if (got_sum !== want.divisor_sum) begin
        mismatches++;
        $error("divisor_sum: expected %0d, actual %0d", want.divisor_sum, got_sum);
      end
      if (got_error !== want.range_error) begin
        mismatches++;
        $error("range_error: expected %b, actual %b", want.range_error, got_error);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  bound_t low_bound = '0;
  bound_t high_bound = '0;
  logic   busy;
  logic   done;
  sum_t   divisor_sum;
  logic   range_error;

  bit          gaps_on = 1'b1;
  int unsigned stall_cycles = 0;
  divisor_sum_tracker tracker = new();

  divisor_count_range_sum #(
    .MAX_N     (MAX_N),
    .SUM_WIDTH (SUM_WIDTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .low_bound   (low_bound),
    .high_bound  (high_bound),
    .done        (done),
    .divisor_sum (divisor_sum),
    .range_error (range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // present one query, possibly after idle cycles, and hold it until the transfer
  task automatic send_query(bound_t lo, bound_t hi);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(99) < 17) begin
        start <= 1'b0;
      end else begin
        start      <= 1'b1;
        low_bound  <= lo;
        high_bound <= hi;
        break;
      end
    end
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pick_query(output bound_t lo, output bound_t hi);
    int unsigned kind, a, b, span;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // ordinary range inside the table, mostly short
      span = ($urandom_range(3) == 0) ? $urandom_range(MAX_N) : $urandom_range(300);
      a = $urandom_range(MAX_N - span);
      lo = bound_t'(a);
      hi = bound_t'(a + span);
    end else if (kind < 55) begin
      // swapped ends anywhere in the field
      b = $urandom_range(BOUND_TOP - 1);
      a = $urandom_range(BOUND_TOP, b + 1);
      lo = bound_t'(a);
      hi = bound_t'(b);
    end else if (kind < 70) begin
      lo = bound_t'($urandom);
      hi = bound_t'($urandom);
    end else if (kind < 80) begin
      // around the top of the table, where the high end gets clamped
      lo = bound_t'($urandom_range(MAX_N + 64, MAX_N - 64));
      hi = bound_t'($urandom_range(BOUND_TOP, MAX_N - 64));
    end else if (kind < 90) begin
      a = $urandom_range(MAX_N);
      lo = bound_t'(a);
      hi = bound_t'(a);
    end else begin
      lo = bound_t'($urandom_range(64));
      hi = bound_t'($urandom_range(64));
    end
  endtask

  initial begin
    bound_t      lo, hi;
    int unsigned k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the first query waits at start through the whole build
    for (k = 0; k < DIRECTED_COUNT; k++) begin
      send_query(EDGE_LO[k], EDGE_HI[k]);
    end
    for (k = 0; k < RANDOM_QUERIES; k++) begin
      gaps_on = !(k >= 700 && k < 1100);
      pick_query(lo, hi);
      send_query(lo, hi);
    end
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (done === 1'b1) begin
      tracker.check_sum(divisor_sum, range_error);
      moved = 1'b1;
    end
    if (!rst && start && busy === 1'b0) begin
      tracker.add_query(low_bound, high_bound);
      moved = 1'b1;
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/core/dcrs_pkg.sv
rtl/core/dcrs_ctrl.sv
rtl/core/dcrs_dp.sv
rtl/core/divisor_count_range_sum.sv
test/tb_top.sv
